>>> rtl/klex_pkg.sv
package klex_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 32;

  localparam logic [3:0] KIND_ERROR   = 4'd0;
  localparam logic [3:0] KIND_VAR     = 4'd1;
  localparam logic [3:0] KIND_COLON   = 4'd2;
  localparam logic [3:0] KIND_ID      = 4'd3;
  localparam logic [3:0] KIND_COMMA   = 4'd4;
  localparam logic [3:0] KIND_INTEGER = 4'd5;
  localparam logic [3:0] KIND_REAL    = 4'd6;
  localparam logic [3:0] KIND_SEMI    = 4'd7;
  localparam logic [3:0] KIND_ASSIGN  = 4'd8;
  localparam logic [3:0] KIND_IF      = 4'd9;
  localparam logic [3:0] KIND_THEN    = 4'd10;
  localparam logic [3:0] KIND_PLUS    = 4'd11;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // keyword table indexes
  localparam int NUM_KW = 6;
  localparam logic [2:0] KW_VAR     = 3'd0;
  localparam logic [2:0] KW_INTEGER = 3'd1;
  localparam logic [2:0] KW_REAL    = 3'd2;
  localparam logic [2:0] KW_IF      = 3'd3;
  localparam logic [2:0] KW_THEN    = 3'd4;
  localparam logic [2:0] KW_ASSIGN  = 3'd5;

  // keyword bytes, first character in the lowest byte
  function automatic logic [63:0] kw_text(input logic [2:0] kw);
    logic [63:0] t;
    t = '0;
    unique case (kw)
      KW_VAR:     t = 64'h0000_0000_0072_6176;
      KW_INTEGER: t = 64'h0072_6567_6574_6E69;
      KW_REAL:    t = 64'h0000_0000_6C61_6572;
      KW_IF:      t = 64'h0000_0000_0000_6669;
      KW_THEN:    t = 64'h0000_0000_6E65_6874;
      KW_ASSIGN:  t = 64'h0000_0000_0000_3D3A;
      default:    t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] kw);
    logic [3:0] n;
    n = 4'd0;
    unique case (kw)
      KW_VAR:     n = 4'd3;
      KW_INTEGER: n = 4'd7;
      KW_REAL:    n = 4'd4;
      KW_IF:      n = 4'd2;
      KW_THEN:    n = 4'd4;
      KW_ASSIGN:  n = 4'd2;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic kw_hit(input logic [2:0] kw, input logic [2:0] pos,
                                  input logic [7:0] c);
    logic [63:0] t;
    t = kw_text(kw);
    return ({1'b0, pos} < kw_len(kw)) && (t[{pos, 3'b000} +: 8] == c);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_NL;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == CH_COLON || c == CH_COMMA || c == CH_SEMI || c == CH_PLUS;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

>>> rtl/klex_ram.sv
module klex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/keyword_token_lexer.sv
// one character beat is taken per cycle while no token is being sent
// a beat that ends a token holds in_tready low until every character of that token has been read
// from the buffer ram into the output register, one entry at a time with a single read in flight
// and each read issued only while the output register is empty or being taken
// synchronous active-low reset clears fill, flags and the sequencer, sets line to 1
// and column to 0; the buffer ram is not cleared, only written entries are read
module keyword_token_lexer
  import klex_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] token_kind, [9:4] token_length, [17:10] lexeme_char,
  // [33:18] line_number, [49:34] column_number, [55:50] zero
  output logic [55:0] out_tdata,
  output logic        out_tlast   // last_char
);

  localparam int FILL_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_TOKEN_LEN);
  localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_TOKEN_LEN);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic              state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic              idok_r, idok_nxt;
  logic [NUM_KW-1:0] m_r, m_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [7:0]        second_r, second_nxt;
  logic [15:0]       line_r, line_nxt;
  logic [15:0]       col_r, col_nxt;

  logic [3:0]        kind_r;
  logic [FILL_W-1:0] len_r;
  logic [15:0]       eline_r, ecol_r;
  logic [FILL_W-1:0] rd_idx_r;
  logic              rd_pend_r;
  logic              pend_wr_r;
  logic [7:0]        pend_char_r;

  logic              out_valid_r;
  logic [3:0]        o_kind_r;
  logic [5:0]        o_len_r;
  logic [7:0]        o_char_r;
  logic [15:0]       o_line_r, o_col_r;
  logic              o_last_r;

  logic [7:0]        c;
  logic              in_fire, is_eoi, c_white, ends_char, emit_go;
  logic [FILL_W-1:0] fill0;
  logic [3:0]        kind_now;
  logic              done, issue;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign c       = in_tdata;
  assign is_eoi  = in_tuser;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire = in_tvalid & in_tready;
  assign c_white = is_white(c);

  always_comb begin
    priority if (is_punct(c) || c_white) begin
      ends_char = (fill_r != '0);
    end else if (fill_r == FILL_W'(1) && is_punct(first_r) && c != CH_EQ) begin
      ends_char = 1'b1;
    end else if (fill_r >= FILL_W'(2) && first_r == CH_COLON && second_r == CH_EQ) begin
      ends_char = 1'b1;
    end else begin
      ends_char = 1'b0;
    end
  end

  assign emit_go = in_fire & (is_eoi ? (fill_r != '0) : ends_char);
  assign fill0   = ends_char ? '0 : fill_r;

  // classification from flags kept while the token was collected
  always_comb begin
    priority if (ovf_r) begin
      kind_now = KIND_ERROR;
    end else if (m_r[KW_VAR] && fill_r == FILL_W'(3)) begin
      kind_now = KIND_VAR;
    end else if (fill_r == FILL_W'(1) && first_r == CH_COLON) begin
      kind_now = KIND_COLON;
    end else if (fill_r == FILL_W'(1) && first_r == CH_COMMA) begin
      kind_now = KIND_COMMA;
    end else if (m_r[KW_INTEGER] && fill_r == FILL_W'(7)) begin
      kind_now = KIND_INTEGER;
    end else if (m_r[KW_REAL] && fill_r == FILL_W'(4)) begin
      kind_now = KIND_REAL;
    end else if (fill_r == FILL_W'(1) && first_r == CH_SEMI) begin
      kind_now = KIND_SEMI;
    end else if (m_r[KW_ASSIGN] && fill_r == FILL_W'(2)) begin
      kind_now = KIND_ASSIGN;
    end else if (m_r[KW_IF] && fill_r == FILL_W'(2)) begin
      kind_now = KIND_IF;
    end else if (m_r[KW_THEN] && fill_r == FILL_W'(4)) begin
      kind_now = KIND_THEN;
    end else if (fill_r == FILL_W'(1) && first_r == CH_PLUS) begin
      kind_now = KIND_PLUS;
    end else if (idok_r && fill_r != '0) begin
      kind_now = KIND_ID;
    end else begin
      kind_now = KIND_ERROR;
    end
  end

  always_comb begin
    fill_nxt   = fill_r;
    ovf_nxt    = ovf_r;
    idok_nxt   = idok_r;
    m_nxt      = m_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    if (in_fire) begin
      if (is_eoi) begin
        if (fill_r != '0) begin
          fill_nxt = '0;
          ovf_nxt  = 1'b0;
        end
      end else begin
        col_nxt = sat_inc(col_r);
        if (ends_char) begin
          fill_nxt = '0;
          ovf_nxt  = 1'b0;
        end
        if (!c_white) begin
          if (fill0 < MAX_FILL) begin
            fill_nxt = fill0 + FILL_W'(1);
            if (fill0 == '0) begin
              first_nxt = c;
              idok_nxt  = is_letter(c);
            end else begin
              idok_nxt = idok_r & (is_letter(c) | is_digit(c));
            end
            if (fill0 == FILL_W'(1)) begin
              second_nxt = c;
            end
            for (int k = 0; k < NUM_KW; k++) begin
              if (fill0 == '0) begin
                m_nxt[k] = kw_hit(3'(k), 3'd0, c);
              end else begin
                m_nxt[k] = m_r[k] & (fill0 < FILL_W'(8)) & kw_hit(3'(k), fill0[2:0], c);
              end
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (c == CH_NL) begin
          line_nxt = sat_inc(line_r);
          col_nxt  = '0;
        end
      end
    end
  end

  // read sweep: one read in flight, issued only when the output slot frees
  assign done  = (state_r == S_EMIT) && (rd_idx_r == len_r) && !rd_pend_r;
  assign issue = (state_r == S_EMIT) && (rd_idx_r != len_r) && !rd_pend_r &&
                 (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    if (emit_go) begin
      state_nxt = S_EMIT;
    end else if (done) begin
      state_nxt = S_IDLE;
    end
  end

  // a character that starts a new token waits until the old one has been read out
  assign ram_we    = done ? pend_wr_r
                          : (in_fire & !is_eoi & !c_white & !ends_char & (fill0 < MAX_FILL));
  assign ram_waddr = done ? '0 : fill0[ADDR_W-1:0];
  assign ram_wdata = done ? pend_char_r : c;

  klex_ram #(
    .WIDTH(8),
    .DEPTH(MAX_TOKEN_LEN)
  ) u_buf (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .re      (issue),
    .rd_addr (rd_idx_r[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      idok_r      <= 1'b0;
      m_r         <= '0;
      line_r      <= 16'd1;
      col_r       <= '0;
      rd_idx_r    <= '0;
      len_r       <= '0;
      rd_pend_r   <= 1'b0;
      pend_wr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      ovf_r     <= ovf_nxt;
      idok_r    <= idok_nxt;
      m_r       <= m_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      rd_pend_r <= issue;
      if (emit_go) begin
        len_r     <= fill_r;
        rd_idx_r  <= '0;
        pend_wr_r <= !is_eoi & !c_white;
      end else begin
        if (issue) begin
          rd_idx_r <= rd_idx_r + FILL_W'(1);
        end
        if (done) begin
          pend_wr_r <= 1'b0;
        end
      end
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
    if (emit_go) begin
      kind_r      <= kind_now;
      eline_r     <= line_r;
      ecol_r      <= col_r;
      pend_char_r <= c;
    end
    if (rd_pend_r) begin
      o_kind_r <= kind_r;
      o_len_r  <= 6'(len_r);
      o_char_r <= ram_rdata;
      o_line_r <= eline_r;
      o_col_r  <= ecol_r;
      o_last_r <= (rd_idx_r == len_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, o_col_r, o_line_r, o_char_r, o_len_r, o_kind_r};
  assign out_tlast  = o_last_r;

  a_land_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("ram read lands on a full output register");

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAX_FILL)
    else $error("token fill beyond buffer depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> fill_r == MAX_FILL)
    else $error("overflow flagged on a buffer that is not full");

  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> (len_r != '0 && rd_idx_r <= len_r))
    else $error("read sweep index out of range");

  a_no_wr_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !done) |-> !ram_we)
    else $error("buffer written during read sweep");

endmodule
